FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define HUGS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define HUGS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/hugs_pkg.sv
// Shared types and constants of the glyph stream block.
package hugs_pkg;

  localparam int RUN_DEPTH = 63;
  localparam int LEN_W     = $clog2(RUN_DEPTH + 1);
  localparam int ADDR_W    = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [7:0]  LEAD_RST   = 8'd215;
  localparam logic [15:0] BASE_RST   = 16'd55184;
  localparam logic [7:0]  OFFSET_RST = 8'd0;

  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7A;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEAD   = 2'd0,
    CFG_BASE   = 2'd1,
    CFG_OFFSET = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FL_RD,
    ST_FL_OUT,
    ST_TAIL
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic load_flush;
    logic load_tail_now;
    logic load_tail;
  } dp_cmd_t;

  typedef struct packed {
    logic flush_go;
    logic tail_go;
    logic out_free;
    logic len_is_one;
    logic tail_pend;
  } dp_sts_t;

endpackage

FILE: rtl/hugs_dp.sv
// Datapath: config registers, byte decode, run store and output register.
module hugs_dp import hugs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_end_marker,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [7:0]           out_glyph_code,
  output logic                 out_from_reversed_run,
  output logic                 out_last_of_burst,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts
);

  logic [7:0]       lead_r;
  logic [15:0]      base_r;
  logic [7:0]       offset_r;
  logic             lead_pending_r, lead_pending_nxt;
  logic [LEN_W-1:0] run_length_r, run_length_nxt;
  logic             tail_pend_r;
  logic [7:0]       tail_code_r;
  logic [7:0]       rd_data_r;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_code_r;
  logic             out_rev_r;
  logic             out_last_r;

  logic [7:0]       store_mem [RUN_DEPTH];

  logic             run_active;
  logic             is_letter;
  logic             stops;
  logic [7:0]       glyph;
  logic             wr_en;
  logic [LEN_W-1:0] len_acc;
  logic             flush_go;
  logic             tail_go;
  logic [7:0]       tail_code;
  logic             pend_acc;
  logic [LEN_W-1:0] rd_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r   <= LEAD_RST;
      base_r   <= BASE_RST;
      offset_r <= OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEAD:   lead_r   <= cfg_wdata[7:0];
        CFG_BASE:   base_r   <= cfg_wdata;
        CFG_OFFSET: offset_r <= cfg_wdata[7:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    run_active = (run_length_r != '0);
    is_letter  = ((in_text_byte >= CH_UP_A) && (in_text_byte <= CH_UP_Z)) ||
                 ((in_text_byte >= CH_LO_A) && (in_text_byte <= CH_LO_Z));
    stops      = (in_text_byte == CH_LF) || (in_text_byte == CH_CR) ||
                 (in_text_byte == lead_r);
    // only the low byte of (lead:byte - base + offset) survives
    glyph      = in_text_byte - base_r[7:0] + offset_r;
    wr_en      = 1'b0;
    len_acc    = run_length_r;
    flush_go   = 1'b0;
    tail_go    = 1'b0;
    tail_code  = in_text_byte;
    pend_acc   = 1'b0;
    if (in_end_marker) begin
      flush_go = run_active;
    end else if (lead_pending_r) begin
      tail_go   = (glyph != 8'd0);
      tail_code = glyph;
    end else if (run_active && !stops) begin
      wr_en    = 1'b1;
      len_acc  = run_length_r + LEN_W'(1);
      flush_go = (len_acc >= LEN_W'(RUN_DEPTH));
    end else begin
      flush_go = run_active;
      if (in_text_byte == lead_r) begin
        pend_acc = 1'b1;
      end else if (is_letter) begin
        wr_en    = 1'b1;
        len_acc  = LEN_W'(1);
        flush_go = (len_acc >= LEN_W'(RUN_DEPTH));
      end else begin
        tail_go = 1'b1;
      end
    end
  end

  always_comb begin
    lead_pending_nxt = lead_pending_r;
    run_length_nxt   = run_length_r;
    if (cmd.accept) begin
      lead_pending_nxt = pend_acc;
      run_length_nxt   = len_acc;
    end else if (cmd.load_flush) begin
      run_length_nxt = run_length_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r <= 1'b0;
      run_length_r   <= '0;
      tail_pend_r    <= 1'b0;
    end else begin
      lead_pending_r <= lead_pending_nxt;
      run_length_r   <= run_length_nxt;
      if (cmd.accept) begin
        tail_pend_r <= tail_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tail_code_r <= tail_code;
    end
  end

  assign rd_idx = run_length_r - LEN_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      store_mem[run_length_r[ADDR_W-1:0]] <= in_text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= store_mem[rd_idx[ADDR_W-1:0]];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_flush || cmd.load_tail_now || cmd.load_tail) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_flush) begin
      out_code_r <= rd_data_r;
      out_rev_r  <= 1'b1;
      out_last_r <= (run_length_r == LEN_W'(1)) && !tail_pend_r;
    end else if (cmd.load_tail_now) begin
      out_code_r <= tail_code;
      out_rev_r  <= 1'b0;
      out_last_r <= 1'b1;
    end else if (cmd.load_tail) begin
      out_code_r <= tail_code_r;
      out_rev_r  <= 1'b0;
      out_last_r <= 1'b1;
    end
  end

  assign sts.flush_go   = flush_go;
  assign sts.tail_go    = tail_go;
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.len_is_one = (run_length_r == LEN_W'(1));
  assign sts.tail_pend  = tail_pend_r;

  assign out_valid             = out_valid_r;
  assign out_glyph_code        = out_code_r;
  assign out_from_reversed_run = out_rev_r;
  assign out_last_of_burst     = out_last_r;

endmodule

FILE: rtl/hugs_ctrl.sv
// Controller: accepts requests and sequences run flushes and output loads.
module hugs_ctrl import hugs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          if (sts.flush_go) begin
            state_nxt = ST_FL_RD;
          end else if (sts.tail_go) begin
            if (sts.out_free) begin
              cmd.load_tail_now = 1'b1;
            end else begin
              state_nxt = ST_TAIL;
            end
          end
        end
      end
      ST_FL_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_FL_OUT;
      end
      ST_FL_OUT: begin
        if (sts.out_free) begin
          cmd.load_flush = 1'b1;
          if (sts.len_is_one) begin
            state_nxt = sts.tail_pend ? ST_TAIL : ST_IDLE;
          end else begin
            state_nxt = ST_FL_RD;
          end
        end
      end
      ST_TAIL: begin
        if (sts.out_free) begin
          cmd.load_tail = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/hebrew_utf8_rtl_glyph_stream.sv
// Top level of the right-to-left glyph stream block.
// Input channel: one text byte or an end-of-text mark per request (in_valid/in_stall).
// Output channel: glyph codes with a reversed-run flag and a last-of-burst mark
// (out_valid/out_stall); a request gives zero to 63 results.
// Config port: cfg_we with cfg_index 0 = lead byte, 1 = code base, 2 = font offset.
// A byte that passes through or a Hebrew glyph is loaded into the output register
// on acceptance if that register is free; such requests go at one per cycle while
// the output drains. An English run is collected one byte per cycle with no output.
// A flush reads the run store and emits it reversed (read, then load, per byte) and
// holds in_stall high, waiting while the output is held, through the terminator's
// own result. End of text, a full store, or LF, CR or lead byte after a run flushes.
// The output register is loaded whenever it is empty or being taken. A request whose
// result finds it still held parks that result and stalls input until it frees.
// Reset (rst_n low, synchronous) drops any run and pending lead byte, clears the
// output valid flag and restores the config defaults; no clearing pass is needed.
// While out_stall is high a valid result holds and the controller waits to load the next.
module hebrew_utf8_rtl_glyph_stream import hugs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_end_marker,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_glyph_code,
  output logic                 out_from_reversed_run,
  output logic                 out_last_of_burst
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  hugs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  hugs_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_text_byte          (in_text_byte),
    .in_end_marker         (in_end_marker),
    .out_stall             (out_stall),
    .out_valid             (out_valid),
    .out_glyph_code        (out_glyph_code),
    .out_from_reversed_run (out_from_reversed_run),
    .out_last_of_burst     (out_last_of_burst),
    .cmd                   (cmd),
    .sts                   (sts)
  );

endmodule

FILE: rtl/hugs_chk.sv
// Port-level checker for the glyph stream block, bound to the top level.
`include "assert_macros.svh"

module hugs_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_glyph_code,
  input logic       out_from_reversed_run,
  input logic       out_last_of_burst
);

  `HUGS_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid, "result dropped while stalled")
  `HUGS_ASSERT(a_out_stable, clk, rst_n, (out_valid && out_stall) |=> $stable(out_glyph_code), "stalled glyph changed")
  `HUGS_ASSERT(a_plain_last, clk, rst_n, (out_valid && !out_from_reversed_run) |-> out_last_of_burst, "plain result not last of burst")
  `HUGS_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> (!out_valid && !in_stall), "reset did not clear output and stall")

endmodule

bind hebrew_utf8_rtl_glyph_stream hugs_chk u_hugs_chk (.*);
